@@ rtl/ssq_pkg.sv @@
// Shared types, constants and helpers for the step sequencer with slide.
package ssq_pkg;

    // Defaults for the top-level parameters
    localparam int STEPS_DEF     = 16;
    localparam int FRAC_BITS_DEF = 12;

    // Field widths
    localparam int POS_W    = 32;
    localparam int IDX_W    = 4;
    localparam int SPITCH_W = 16;
    localparam int LEVEL_W  = 8;
    localparam int PITCH_W  = 20;
    localparam int IN_W     = 72;
    localparam int OUT_W    = 24;

    // Request kinds carried in tuser
    localparam logic MODE_FRAME = 1'b0;
    localparam logic MODE_LOAD  = 1'b1;

    // Gate level that opens the gate for the first half of the step
    localparam logic [LEVEL_W-1:0] GATE_HALF = 8'd128;

    // One stored step: pitch already scaled to semitones
    typedef struct packed {
        logic [LEVEL_W-1:0] slide;
        logic [LEVEL_W-1:0] gate;
        logic [PITCH_W-1:0] pitch;
    } step_entry_t;

    // Per-frame flags handed to the pitch/gate unit
    typedef struct packed {
        logic active;     // playing and position not negative
        logic cur_ok;     // current step written since reset
        logic prev_ok;    // previous step written since reset
    } frame_flags_t;

    // Octave fraction times 12 -> semitones, 16 fraction bits
    function automatic logic [PITCH_W-1:0] scale_pitch(input logic [SPITCH_W-1:0] p);
        logic [PITCH_W-1:0] w;
        begin
            w = PITCH_W'(p);
            scale_pitch = (w << 3) + (w << 2);
        end
    endfunction

endpackage

@@ rtl/step_sequencer_with_slide.sv @@
// Flow: a frame request is registered in stage A, read into stage C, then registered at the output.
// Throughput: one request per cycle, load or frame, while the output is not stalled; loads give no result.
// Stages: reciprocal multiply for the step wrap, step-table read, pitch/gate evaluation.
// Reset clears the per-step valid bits and the held pitch; table contents need
// no clearing pass, an unwritten step reads as zero.
module step_sequencer_with_slide
    import ssq_pkg::*;
#(
    parameter int STEPS     = STEPS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // beat_pos[31:0], playing[32], step_index[36:33], step_pitch[52:37],
    // step_gate[60:53], step_slide[68:61], zero fill[71:69]
    input  logic [IN_W-1:0]  s_axis_tdata,
    // mode[0]
    input  logic             s_axis_tuser,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // pitch_out[19:0], gate_out[20], zero fill[23:21]
    output logic [OUT_W-1:0] m_axis_tdata
);

    localparam int AW      = $clog2(STEPS);
    localparam int XW      = 31 - FRAC_BITS;
    localparam int MW      = XW + 1;
    localparam int PW      = XW + MW;
    localparam int SH      = XW + AW;
    localparam int QW      = PW - SH;
    localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(STEPS) - 64'd1) / 64'(STEPS);
    localparam logic [MW-1:0] RECIP_M = RECIP[MW-1:0];
    localparam logic [AW-1:0] LAST_STEP = AW'(STEPS - 1);

    // Input field split
    logic [POS_W-1:0]    in_pos;
    logic                in_playing;
    logic [IDX_W-1:0]    in_idx;
    logic [SPITCH_W-1:0] in_pitch;
    logic [LEVEL_W-1:0]  in_gate;
    logic [LEVEL_W-1:0]  in_slide;
    logic [6:0]          in_idx_wide;
    logic                in_accept;

    assign in_pos      = s_axis_tdata[31:0];
    assign in_playing  = s_axis_tdata[32];
    assign in_idx      = s_axis_tdata[36:33];
    assign in_pitch    = s_axis_tdata[52:37];
    assign in_gate     = s_axis_tdata[60:53];
    assign in_slide    = s_axis_tdata[68:61];
    assign in_idx_wide = 7'(in_idx);
    assign in_accept   = s_axis_tvalid & s_axis_tready;

    // Stage A: request plus step-wrap product
    logic                 a_valid_reg;
    logic                 a_mode_reg;
    logic                 a_active_reg;
    logic                 a_in_range_reg;
    logic [PW-1:0]        a_prod_reg;
    logic [7:0]           a_xlo_reg;
    logic [FRAC_BITS-1:0] a_phase_reg;
    logic [AW-1:0]        a_idx_reg;
    step_entry_t          a_entry_reg;

    // Stage C: table read data and frame context
    logic                 c_valid_reg;
    frame_flags_t         c_flags_reg;
    logic [FRAC_BITS-1:0] c_phase_reg;
    step_entry_t          c_cur;
    logic [PITCH_W-1:0]   c_prev;

    // Output and held pitch
    logic                 out_valid_reg;
    logic                 gate_reg;
    logic [PITCH_W-1:0]   held_reg;
    logic [PITCH_W-1:0]   held_next;
    logic                 gate_next;

    logic [STEPS-1:0]     valid_reg;

    // Stall chain: each stage moves when the next has room
    logic out_en;
    logic c_ready;
    logic a_ready;
    logic a_move;
    logic c_move;

    assign out_en        = ~out_valid_reg | m_axis_tready;
    assign c_ready       = ~c_valid_reg | out_en;
    assign a_ready       = ~a_valid_reg | c_ready;
    assign s_axis_tready = a_ready;
    assign a_move        = a_valid_reg & c_ready;
    assign c_move        = c_valid_reg & out_en;

    // Step wrap: exact quotient by reciprocal, remainder from low bits
    logic [XW-1:0] in_x;
    logic [PW-1:0] prod_next;
    logic [QW-1:0] quot;
    logic [15:0]   qs;
    logic [7:0]    rem;
    logic [AW-1:0] step;
    logic [AW-1:0] prev_step;

    assign in_x      = in_pos[30:FRAC_BITS];
    assign prod_next = PW'(in_x) * PW'(RECIP_M);
    assign quot      = a_prod_reg[PW-1:SH];
    assign qs        = 8'(quot) * 8'(STEPS);
    assign rem       = a_xlo_reg - qs[7:0];
    assign step      = rem[AW-1:0];
    assign prev_step = (step == '0) ? LAST_STEP : (step - AW'(1));

    // Stage A capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            a_mode_reg        <= s_axis_tuser;
            a_active_reg      <= in_playing & ~in_pos[31];
            a_in_range_reg    <= in_idx_wide < 7'(STEPS);
            a_prod_reg        <= prod_next;
            a_xlo_reg         <= 8'(in_x);
            a_phase_reg       <= in_pos[FRAC_BITS-1:0];
            a_idx_reg         <= in_idx_wide[AW-1:0];
            a_entry_reg.pitch <= scale_pitch(in_pitch);
            a_entry_reg.gate  <= in_gate;
            a_entry_reg.slide <= in_slide;
        end
    end

    // Table access: loads write, frames read, both in request order
    logic tbl_wr;
    logic tbl_rd;

    assign tbl_wr = a_move & (a_mode_reg == MODE_LOAD) & a_in_range_reg;
    assign tbl_rd = a_move & (a_mode_reg == MODE_FRAME);

    ssq_ram
    #(
        .WIDTH ($bits(step_entry_t)),
        .DEPTH (STEPS)
    )
    u_cur_ram
    (
        .clk     (clk),
        .wr_en   (tbl_wr),
        .wr_addr (a_idx_reg),
        .wr_data (a_entry_reg),
        .rd_en   (tbl_rd),
        .rd_addr (step),
        .rd_data (c_cur)
    );

    ssq_ram
    #(
        .WIDTH (PITCH_W),
        .DEPTH (STEPS)
    )
    u_prev_ram
    (
        .clk     (clk),
        .wr_en   (tbl_wr),
        .wr_addr (a_idx_reg),
        .wr_data (a_entry_reg.pitch),
        .rd_en   (tbl_rd),
        .rd_addr (prev_step),
        .rd_data (c_prev)
    );

    // Written-entry bits and stage C control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            c_valid_reg <= 1'b0;
            c_flags_reg <= '0;
        end
        else
        begin
            if (tbl_wr)
            begin
                valid_reg[a_idx_reg] <= 1'b1;
            end
            if (c_ready)
            begin
                c_valid_reg <= a_valid_reg & (a_mode_reg == MODE_FRAME);
            end
            if (tbl_rd)
            begin
                c_flags_reg.active  <= a_active_reg;
                c_flags_reg.cur_ok  <= valid_reg[step];
                c_flags_reg.prev_ok <= valid_reg[prev_step];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_rd)
        begin
            c_phase_reg <= a_phase_reg;
        end
    end

    // Pitch and gate for the frame in stage C
    ssq_pitch
    #(
        .FRAC_BITS (FRAC_BITS)
    )
    u_pitch
    (
        .flags    (c_flags_reg),
        .phase    (c_phase_reg),
        .cur_raw  (c_cur),
        .prev_raw (c_prev),
        .held     (held_reg),
        .pitch    (held_next),
        .gate     (gate_next)
    );

    // Output register; held pitch doubles as the pitch field
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            gate_reg      <= 1'b0;
            held_reg      <= '0;
        end
        else
        begin
            if (out_en)
            begin
                out_valid_reg <= c_valid_reg;
            end
            if (c_move)
            begin
                gate_reg <= gate_next;
                held_reg <= held_next;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, gate_reg, held_reg};

endmodule

@@ rtl/ssq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ssq_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/ssq_pitch.sv @@
// Pitch and gate evaluation for one frame: hold, step pitch or linear glide.
module ssq_pitch
    import ssq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  frame_flags_t          flags,
    input  logic [FRAC_BITS-1:0]  phase,
    input  step_entry_t           cur_raw,
    input  logic [PITCH_W-1:0]    prev_raw,
    input  logic [PITCH_W-1:0]    held,
    output logic [PITCH_W-1:0]    pitch,
    output logic                  gate
);

    localparam int PROD_W = PITCH_W + FRAC_BITS + 1;

    step_entry_t          cur;
    logic [PITCH_W-1:0]   prev;
    logic                 first_half;
    logic                 past_half;
    logic                 rising;
    logic [PITCH_W-1:0]   diff;
    logic [FRAC_BITS:0]   twice;
    logic [PROD_W-1:0]    prod;
    logic [PITCH_W-1:0]   offset;
    logic [PITCH_W-1:0]   glided;

    // Entries never written read as zero
    assign cur  = flags.cur_ok ? cur_raw : '0;
    assign prev = flags.prev_ok ? prev_raw : '0;

    assign first_half = ~phase[FRAC_BITS-1];
    assign past_half  = phase[FRAC_BITS-1] & (|phase[FRAC_BITS-2:0]);

    // Glide from previous step pitch; offset truncates toward the start
    assign rising = cur.pitch >= prev;
    assign diff   = rising ? (cur.pitch - prev) : (prev - cur.pitch);
    assign twice  = {phase, 1'b0};
    assign prod   = PROD_W'(diff) * PROD_W'(twice);
    assign offset = prod[FRAC_BITS +: PITCH_W];
    assign glided = rising ? (prev + offset) : (prev - offset);

    // Gate and held-pitch selection
    always_comb
    begin
        pitch = held;
        gate  = 1'b0;
        if (flags.active && (cur.gate != '0))
        begin
            if ((cur.slide != '0) && first_half)
            begin
                pitch = glided;
            end
            else
            begin
                pitch = cur.pitch;
            end
            if (cur.gate == GATE_HALF)
            begin
                gate = ~past_half;
            end
            else
            begin
                gate = cur.gate > GATE_HALF;
            end
        end
    end

endmodule
